/* sv/rtcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcs_pkg
// Shared types and constants of the three-wire clock chip serial master.
// ----------------------------------------------------------------------------
package rtcs_pkg;

   localparam int MAX_BYTES  = 32;
   localparam int BUF_DEPTH  = 32;
   localparam int BUF_ADDR_W = $clog2(BUF_DEPTH);

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // configuration register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_US = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_US     = 2'd1;
   localparam logic [9:0] TICKS_PER_US_RESET = 10'd16;
   localparam logic [3:0] SETUP_US_RESET     = 4'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] command;
      logic [5:0] byte_count;
      logic [4:0] load_index;
      logic [7:0] load_byte;
      logic       io_in;
   } req_type;

   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_out;
      logic       io_drive;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [BUF_ADDR_W-1:0] idx;
      logic [7:0]            data;
   } buf_wr_type;

endpackage

/* sv/rtcs_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcs_buffer
// Write data buffer: one write port, one registered read port, with bypass
// of the write in flight and of the write of the current request.
// ----------------------------------------------------------------------------
module rtcs_buffer (
   input  logic                            clock,
   input  logic                            reset,
   input  rtcs_pkg::buf_wr_type            wr,
   input  logic [rtcs_pkg::BUF_ADDR_W-1:0] rd_addr,
   output logic [7:0]                      rd_byte
);

   logic [7:0] mem [rtcs_pkg::BUF_DEPTH];

   logic [7:0]                      q_ff;
   logic [rtcs_pkg::BUF_ADDR_W-1:0] addr_ff;
   logic                            fwd_en_ff;
   logic [rtcs_pkg::BUF_ADDR_W-1:0] fwd_idx_ff;
   logic [7:0]                      fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      q_ff        <= mem[rd_addr];
      addr_ff     <= rd_addr;
      fwd_idx_ff  <= wr.idx;
      fwd_data_ff <= wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_en_ff <= 1'b0;
      end else begin
         fwd_en_ff <= wr.en;
      end
   end

   // current request's load comes first, then the write that raced the read
   always_comb begin
      if (wr.en && wr.idx == addr_ff) begin
         rd_byte = wr.data;
      end else if (fwd_en_ff && fwd_idx_ff == addr_ff) begin
         rd_byte = fwd_data_ff;
      end else begin
         rd_byte = q_ff;
      end
   end

endmodule

/* sv/rtcs_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcs_engine
// Transaction sequencer: phase, timing, bit and byte counters, shifter.
// ----------------------------------------------------------------------------
module rtcs_engine #(
   parameter int MAX_BYTES = rtcs_pkg::MAX_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  rtcs_pkg::req_type               item,
   input  logic [9:0]                      ticks_per_us,
   input  logic [3:0]                      setup_us,
   input  logic [7:0]                      buf_byte,
   output rtcs_pkg::rsp_type               rsp,
   output logic [rtcs_pkg::BUF_ADDR_W-1:0] rd_addr
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_PRE      = 3'd1;
   localparam logic [2:0] PH_POST     = 3'd2;
   localparam logic [2:0] PH_CMD_LOW  = 3'd3;
   localparam logic [2:0] PH_CMD_HIGH = 3'd4;
   localparam logic [2:0] PH_DATA_A   = 3'd5;
   localparam logic [2:0] PH_DATA_B   = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] wait_ff, wait_in;
   logic [2:0]  bit_ff, bit_in;
   logic [5:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [5:0]  count_ff, count_in;
   logic        io_ff, io_in;

   logic [9:0]  unit10;
   logic [3:0]  setup_eff;
   logic [13:0] setup_prod;
   logic [15:0] unit_ticks;
   logic [15:0] setup_ticks;
   logic [5:0]  count_sat;
   logic [5:0]  next_idx;

   logic        rd_valid, rd_last, done;
   logic [7:0]  rd_data;

   // zero in a timing register counts as one
   assign unit10      = (ticks_per_us == 10'd0) ? 10'd1 : ticks_per_us;
   assign setup_eff   = (setup_us == 4'd0) ? 4'd1 : setup_us;
   assign setup_prod  = {10'd0, setup_eff} * {4'd0, unit10};
   assign unit_ticks  = {6'd0, unit10};
   assign setup_ticks = {2'd0, setup_prod};
   assign count_sat   = ({1'b0, item.byte_count} > 7'(MAX_BYTES)) ?
                        6'(MAX_BYTES) : item.byte_count;

   always_comb begin
      logic [15:0] wdec;
      logic [2:0]  bit_inc;
      logic        start_byte;
      logic        is_read;

      phase_in = phase_ff;
      wait_in  = wait_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      io_in    = io_ff;
      rd_data  = 8'd0;
      rd_valid = 1'b0;
      rd_last  = 1'b0;
      done     = 1'b0;
      wdec       = (wait_ff != 16'd0) ? wait_ff - 16'd1 : 16'd0;
      bit_inc    = bit_ff + 3'd1;
      start_byte = 1'b0;
      is_read    = cmd_ff[0];

      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            if (item.kind == rtcs_pkg::KIND_START) begin
               cmd_in   = item.command;
               count_in = count_sat;
               bit_in   = 3'd0;
               byte_in  = 6'd0;
               phase_in = PH_PRE;
               wait_in  = setup_ticks;
            end
         end else begin
            wait_in = wdec;
            if (wdec == 16'd0) begin
               case (phase_ff)
                  PH_PRE: begin
                     phase_in = PH_POST;
                     wait_in  = setup_ticks;
                  end
                  PH_POST: begin
                     bit_in   = 3'd0;
                     shift_in = cmd_ff;
                     io_in    = cmd_ff[0];
                     phase_in = PH_CMD_LOW;
                     wait_in  = unit_ticks;
                  end
                  PH_CMD_LOW: begin
                     phase_in = PH_CMD_HIGH;
                     wait_in  = unit_ticks;
                  end
                  PH_CMD_HIGH: begin
                     bit_in = bit_inc;
                     if (bit_inc == 3'd0) begin
                        byte_in    = 6'd0;
                        start_byte = 1'b1;
                     end else begin
                        io_in    = shift_ff[bit_inc];
                        phase_in = PH_CMD_LOW;
                        wait_in  = unit_ticks;
                     end
                  end
                  PH_DATA_A: begin
                     phase_in = PH_DATA_B;
                     wait_in  = unit_ticks;
                  end
                  PH_DATA_B: begin
                     bit_in = bit_inc;
                     if (bit_inc == 3'd0) begin
                        if (is_read) begin
                           rd_data  = shift_ff;
                           rd_valid = 1'b1;
                           rd_last  = ({1'b0, byte_ff} + 7'd1) == {1'b0, count_ff};
                        end
                        byte_in    = byte_ff + 6'd1;
                        start_byte = 1'b1;
                     end else begin
                        if (is_read) begin
                           shift_in[bit_inc] = shift_ff[bit_inc] | item.io_in;
                        end else begin
                           io_in = shift_ff[bit_inc];
                        end
                        phase_in = PH_DATA_A;
                        wait_in  = unit_ticks;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     wait_in  = 16'd0;
                  end
               endcase

               if (start_byte) begin
                  if (byte_in >= count_ff) begin
                     phase_in = PH_IDLE;
                     wait_in  = 16'd0;
                     done     = 1'b1;
                  end else begin
                     bit_in = 3'd0;
                     if (is_read) begin
                        shift_in = {7'd0, item.io_in};
                     end else begin
                        shift_in = buf_byte;
                        io_in    = buf_byte[0];
                     end
                     phase_in = PH_DATA_A;
                     wait_in  = unit_ticks;
                  end
               end
            end
         end
      end
   end

   // prefetch the byte the next byte start would send
   assign next_idx = (phase_in == PH_DATA_A || phase_in == PH_DATA_B) ?
                     byte_in + 6'd1 : 6'd0;
   assign rd_addr  = next_idx[rtcs_pkg::BUF_ADDR_W-1:0];

   // pin levels after this tick
   always_comb begin
      logic ce, sclk, drive;
      ce    = 1'b0;
      sclk  = 1'b0;
      drive = 1'b1;
      case (phase_in)
         PH_POST, PH_CMD_LOW: begin
            ce = 1'b1;
         end
         PH_CMD_HIGH: begin
            ce   = 1'b1;
            sclk = 1'b1;
         end
         PH_DATA_A: begin
            ce = 1'b1;
            if (cmd_in[0]) begin
               sclk  = 1'b1;
               drive = 1'b0;
            end
         end
         PH_DATA_B: begin
            ce = 1'b1;
            if (cmd_in[0]) begin
               drive = 1'b0;
            end else begin
               sclk = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp.chip_enable  = ce;
      rsp.serial_clock = sclk;
      rsp.io_out       = drive & io_in;
      rsp.io_drive     = drive;
      rsp.busy_res     = (phase_in != PH_IDLE);
      rsp.read_data    = rd_data;
      rsp.read_valid   = rd_valid;
      rsp.read_last    = rd_last;
      rsp.done_res     = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= 16'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 6'd0;
         shift_ff <= 8'd0;
         cmd_ff   <= 8'd0;
         count_ff <= 6'd0;
         io_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         cmd_ff   <= cmd_in;
         count_ff <= count_in;
         io_ff    <= io_in;
      end
   end

endmodule

/* sv/three_wire_rtc_serial_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire serial master for a clock chip, stepped one request per tick.
// ----------------------------------------------------------------------------
// Each request is one tick of pin timing and returns exactly one response
// with the pin levels after that tick. A request is taken every clock cycle
// while the response register is empty or being drained, so the block runs
// at one request per cycle; only the response handshake can slow it. Load
// requests write the 32-entry data buffer (a simple dual-port synchronous RAM,
// one write and one read port, the read registered); a start request
// in idle latches command and byte count and runs one transaction: chip
// enable low for the setup wait, chip enable high for a second setup wait,
// the command LSB first with one serial clock pulse per bit, then data bytes
// read or written LSB first.
// The sequencer prefetches the next data byte from the buffer, which bypasses
// any load that lands on the same slot, so loads may occur at any time.
// Configuration registers (index 0 ticks per microsecond, index 1 setup
// microseconds) are written through the csr port, always ready; write them
// only while no transaction is running.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master #(
   parameter int MAX_BYTES = rtcs_pkg::MAX_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rtcs_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rtcs_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rtcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rtcs_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [9:0]            ticks_ff;
   logic [3:0]            setup_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rtcs_pkg::rsp_type     rsp_payload_ff;
   rtcs_pkg::rsp_type     eng_rsp;
   rtcs_pkg::buf_wr_type  buf_wr;
   logic [rtcs_pkg::BUF_ADDR_W-1:0] rd_addr;
   logic [7:0]            buf_byte;
   logic                  accept;

   // advance whenever the response slot frees up this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // a load request writes the buffer at its own tick, busy or not
   assign buf_wr.en   = accept && (req_payload.kind == rtcs_pkg::KIND_LOAD);
   assign buf_wr.idx  = req_payload.load_index;
   assign buf_wr.data = req_payload.load_byte;

   rtcs_buffer u_buffer (
      .clock   (clock),
      .reset   (reset),
      .wr      (buf_wr),
      .rd_addr (rd_addr),
      .rd_byte (buf_byte)
   );

   rtcs_engine #(
      .MAX_BYTES (MAX_BYTES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item         (req_payload),
      .ticks_per_us (ticks_ff),
      .setup_us     (setup_ff),
      .buf_byte     (buf_byte),
      .rsp          (eng_rsp),
      .rd_addr      (rd_addr)
   );

   // configuration registers; writes beyond the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= rtcs_pkg::TICKS_PER_US_RESET;
         setup_ff <= rtcs_pkg::SETUP_US_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rtcs_pkg::CSR_TICKS_PER_US: ticks_ff <= csr_data[9:0];
            rtcs_pkg::CSR_SETUP_US:     setup_ff <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // response register: load on accept, hold while stalled, drop when taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= eng_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
